[rtl/pcs_pkg.sv]
`default_nettype none
package pcs_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int NUM_BINS   = 1 << PIXEL_BITS;
  localparam int COUNT_BITS = 23;
  localparam int CUM_BITS   = COUNT_BITS + PIXEL_BITS;
  localparam int RATIO_BITS = 16;
  localparam int NEED_BITS  = RATIO_BITS + COUNT_BITS;
  localparam int CMP_BITS   = CUM_BITS + RATIO_BITS;
  localparam int ADDR_BITS  = 4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_LOW_RATIO  = 2'd0;
  localparam logic [1:0] REG_HIGH_RATIO = 2'd1;
  localparam logic [1:0] REG_OUT_LOW    = 2'd2;
  localparam logic [1:0] REG_OUT_HIGH   = 2'd3;

  // Item opcodes and result kinds.
  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_MAP        = 1'b1;
  localparam logic KIND_PIXEL    = 1'b0;
  localparam logic KIND_REPORT   = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel_in;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel_out;
    logic [7:0] low_bound;
    logic [7:0] high_bound;
    logic       status;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic                  en;
    logic [PIXEL_BITS-1:0] addr;
    logic [COUNT_BITS-1:0] data;
  } hist_wr_t;

endpackage
`default_nettype wire

[rtl/pcs_hist.sv]
`default_nettype none
module pcs_hist (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          clr_all,
  input  wire pcs_pkg::hist_wr_t             wr,
  input  wire logic [pcs_pkg::PIXEL_BITS-1:0] ra_a,
  input  wire logic [pcs_pkg::PIXEL_BITS-1:0] ra_b,
  output logic      [pcs_pkg::COUNT_BITS-1:0] rd_a,
  output logic      [pcs_pkg::COUNT_BITS-1:0] rd_b
);
  import pcs_pkg::*;

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]   vld_r;
  logic [COUNT_BITS-1:0] dat_a_r, dat_b_r;
  logic                  hit_a_r, hit_b_r;

  // Bin storage with one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    dat_a_r <= mem[ra_a];
    dat_b_r <= mem[ra_b];
  end

  // Per-bin valid flags; a bin that is not valid reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      vld_r   <= '0;
      hit_a_r <= 1'b0;
      hit_b_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      hit_a_r <= vld_r[ra_a];
      hit_b_r <= vld_r[ra_b];
    end
  end

  assign rd_a = hit_a_r ? dat_a_r : '0;
  assign rd_b = hit_b_r ? dat_b_r : '0;

endmodule
`default_nettype wire

[rtl/pcs_div.sv]
`default_nettype none
module pcs_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] num,
  input  wire logic [7:0]  den,
  output logic             done,
  output logic      [15:0] quot
);
  import pcs_pkg::*;

  logic [15:0] quot_r, quot_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [7:0]  den_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  // One restoring step per cycle, most significant bit first.
  always_comb begin
    logic [8:0] shifted;
    shifted  = {rem_r[7:0], quot_r[15]};
    quot_nxt = {quot_r[14:0], 1'b0};
    rem_nxt  = shifted;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = num;
      rem_nxt  = '0;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt     = shifted - {1'b0, den_r};
        quot_nxt[0] = 1'b1;
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      quot_nxt = quot_r;
      rem_nxt  = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

[rtl/percentile_contrast_stretch.sv]
`default_nettype none
// Percentile contrast stretch for 8-bit gray pixels. Accumulate transactions
// count pixels into a 256-bin histogram held in a memory with two read
// ports; each one reads its bin on acceptance, then does a saturating write
// back. The accumulate transaction that carries frame_last adds a bound
// search: the two thresholds are formed first, then one bin pair per cycle
// is taken from both ends of the memory through a three-stage read, sum and
// compare pipeline, before the bounds report is returned. Map transactions
// give the result directly when the pixel is clipped or the bounds are
// equal, and otherwise go through the 16-step serial divider. A new
// transaction is taken only once the previous one is finished. Bins are
// cleared at once by per-bin valid flags, at reset and during the map
// transaction that carries frame_last, so no clearing pass is needed.
module percentile_contrast_stretch (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire pcs_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output pcs_pkg::out_item_t                out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pcs_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);
  import pcs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC_WR, S_NEED, S_SCAN, S_MAP, S_DIV_GO, S_DIV_WAIT, S_EMIT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [15:0] low_ratio_r, high_ratio_r;
  logic [7:0]  out_low_r, out_high_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_ratio_r  <= 16'd655;
      high_ratio_r <= 16'd655;
      out_low_r    <= 8'd0;
      out_high_r   <= 8'd255;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LOW_RATIO:  low_ratio_r  <= pwdata[15:0];
        REG_HIGH_RATIO: high_ratio_r <= pwdata[15:0];
        REG_OUT_LOW:    out_low_r    <= pwdata[7:0];
        REG_OUT_HIGH:   out_high_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LOW_RATIO:  prdata = {16'd0, low_ratio_r};
      REG_HIGH_RATIO: prdata = {16'd0, high_ratio_r};
      REG_OUT_LOW:    prdata = {24'd0, out_low_r};
      REG_OUT_HIGH:   prdata = {24'd0, out_high_r};
      default:        prdata = '0;
    endcase
  end

  // Parameter error on the current register values.
  logic [16:0] ratio_sum;
  logic        param_err;
  assign ratio_sum = {1'b0, low_ratio_r} + {1'b0, high_ratio_r};
  assign param_err = ratio_sum[16] || (out_low_r > out_high_r);

  // Histogram memory.
  hist_wr_t              hwr;
  logic                  hclr;
  logic [PIXEL_BITS-1:0] ra_a, ra_b;
  logic [COUNT_BITS-1:0] rd_a, rd_b;

  pcs_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr_all (hclr),
    .wr      (hwr),
    .ra_a    (ra_a),
    .ra_b    (ra_b),
    .rd_a    (rd_a),
    .rd_b    (rd_b)
  );

  // Divider for the stretch ratio.
  logic        div_start, div_done;
  logic [15:0] div_quot;
  logic [15:0] prod_r;
  logic [7:0]  span_r;

  pcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (span_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  in_item_t              item_r;
  logic [COUNT_BITS-1:0] total_r;
  logic [7:0]            low_level_r, high_level_r;
  logic [NEED_BITS-1:0]  need_lo_r, need_hi_r;
  logic [8:0]            cnt_r;
  logic                  rd_vld_r, cmp_vld_r;
  logic [7:0]            rd_idx_r, cmp_idx_r;
  logic [CUM_BITS-1:0]   cum_lo_r, cum_hi_r;
  logic                  found_lo_r, found_hi_r;
  logic [7:0]            lo_r, hi_r;
  logic [7:0]            res_r;
  logic                  accept;
  logic                  scan_done;
  logic                  emit_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign ra_a      = (state_r == S_SCAN) ? cnt_r[7:0] : in_data.pixel_in;
  assign ra_b      = ~cnt_r[7:0];
  assign scan_done = cnt_r[8] && !rd_vld_r && !cmp_vld_r;
  assign div_start = (state_r == S_DIV_GO);
  assign hclr      = (state_r == S_MAP) && item_r.frame_last;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid || out_ready);

  // Saturating write back of the bin read on acceptance.
  always_comb begin
    hwr.en   = (state_r == S_ACC_WR);
    hwr.addr = item_r.pixel_in;
    hwr.data = (rd_a == COUNT_MAX) ? rd_a : rd_a + COUNT_BITS'(1);
  end

  // Control sequencer with the bound search and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      low_level_r  <= '0;
      high_level_r <= '0;
      out_valid    <= 1'b0;
      rd_vld_r     <= 1'b0;
      cmp_vld_r    <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (out_valid && out_ready && !emit_fire) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r  <= in_data;
            state_r <= (in_data.opcode == OP_ACCUMULATE) ? S_ACC_WR : S_MAP;
          end
        end
        S_ACC_WR: begin
          if (total_r != COUNT_MAX) begin
            total_r <= total_r + COUNT_BITS'(1);
          end
          state_r <= item_r.frame_last ? S_NEED : S_IDLE;
        end
        S_NEED: begin
          need_lo_r  <= NEED_BITS'(low_ratio_r) * NEED_BITS'(total_r);
          need_hi_r  <= NEED_BITS'(high_ratio_r) * NEED_BITS'(total_r);
          cnt_r      <= '0;
          cum_lo_r   <= '0;
          cum_hi_r   <= '0;
          found_lo_r <= 1'b0;
          found_hi_r <= 1'b0;
          lo_r       <= 8'd0;
          hi_r       <= 8'd255;
          state_r    <= S_SCAN;
        end
        S_SCAN: begin
          // Stage one: issue reads of bin cnt and its mirror.
          rd_vld_r <= !cnt_r[8];
          rd_idx_r <= cnt_r[7:0];
          if (!cnt_r[8]) begin
            cnt_r <= cnt_r + 9'd1;
          end
          // Stage two: extend the cumulative sums.
          cmp_vld_r <= rd_vld_r;
          cmp_idx_r <= rd_idx_r;
          if (rd_vld_r) begin
            cum_lo_r <= cum_lo_r + CUM_BITS'(rd_a);
            cum_hi_r <= cum_hi_r + CUM_BITS'(rd_b);
          end
          // Stage three: first level that meets each threshold.
          if (cmp_vld_r) begin
            if (!found_lo_r && ({cum_lo_r, 16'd0} >= CMP_BITS'(need_lo_r))) begin
              found_lo_r <= 1'b1;
              lo_r       <= cmp_idx_r;
            end
            if (!found_hi_r && ({cum_hi_r, 16'd0} >= CMP_BITS'(need_hi_r))) begin
              found_hi_r <= 1'b1;
              hi_r       <= ~cmp_idx_r;
            end
          end
          if (scan_done) begin
            low_level_r  <= lo_r;
            high_level_r <= hi_r;
            state_r      <= S_EMIT;
          end
        end
        S_MAP: begin
          if (item_r.frame_last) begin
            total_r <= '0;
          end
          if (item_r.pixel_in < low_level_r) begin
            res_r   <= 8'd0;
            state_r <= S_EMIT;
          end else if (item_r.pixel_in > high_level_r) begin
            res_r   <= out_high_r;
            state_r <= S_EMIT;
          end else if (high_level_r == low_level_r) begin
            res_r   <= out_low_r;
            state_r <= S_EMIT;
          end else begin
            prod_r  <= {8'd0, item_r.pixel_in - low_level_r} *
                       {8'd0, out_high_r - out_low_r};
            span_r  <= high_level_r - low_level_r;
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            res_r   <= out_low_r + div_quot[7:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            out_valid           <= 1'b1;
            out_data.low_bound  <= low_level_r;
            out_data.high_bound <= high_level_r;
            out_data.status     <= param_err;
            if (item_r.opcode == OP_ACCUMULATE) begin
              out_data.kind      <= KIND_REPORT;
              out_data.pixel_out <= 8'd0;
              out_data.last_out  <= 1'b0;
            end else begin
              out_data.kind      <= KIND_PIXEL;
              out_data.pixel_out <= param_err ? 8'd0 : res_r;
              out_data.last_out  <= item_r.frame_last;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/tb_top.sv]
module tb_top;
  import pcs_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  percentile_contrast_stretch DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the block state.
  logic [22:0] bin_count [NUM_BINS];
  logic [22:0] frame_count;
  logic [7:0]  dark_level;
  logic [7:0]  bright_level;
  logic [15:0] dark_ratio;
  logic [15:0] bright_ratio;
  logic [7:0]  floor_level;
  logic [7:0]  ceil_level;

  out_item_t expected_q[$];
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #400000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic bad_params();
    return ({1'b0, dark_ratio} + {1'b0, bright_ratio} >= 17'd65536) ||
           (floor_level > ceil_level);
  endfunction

  function automatic void clear_histogram();
    foreach (bin_count[i]) bin_count[i] = '0;
    frame_count = '0;
  endfunction

  // Cumulative search from both ends of the histogram.
  function automatic void find_bounds();
    logic [63:0] dark_need;
    logic [63:0] bright_need;
    logic [63:0] dark_sum;
    logic [63:0] bright_sum;
    logic dark_hit;
    logic bright_hit;
    dark_need = 64'(dark_ratio) * 64'(frame_count);
    bright_need = 64'(bright_ratio) * 64'(frame_count);
    dark_sum = 0;
    bright_sum = 0;
    dark_hit = 0;
    bright_hit = 0;
    dark_level = 8'd0;
    bright_level = 8'd255;
    for (int i = 0; i < NUM_BINS; i++) begin
      dark_sum += 64'(bin_count[i]);
      bright_sum += 64'(bin_count[255 - i]);
      if (!dark_hit && (dark_sum << 16) >= dark_need) begin
        dark_hit = 1;
        dark_level = 8'(i);
      end
      if (!bright_hit && (bright_sum << 16) >= bright_need) begin
        bright_hit = 1;
        bright_level = 8'(255 - i);
      end
    end
  endfunction

  function automatic logic [7:0] stretch_level(logic [7:0] p);
    int span;
    if (p < dark_level) return 8'd0;
    if (p > bright_level) return ceil_level;
    if (bright_level == dark_level) return floor_level;
    span = int'(p - dark_level) * (int'(ceil_level) - int'(floor_level));
    return 8'(int'(floor_level) + span / int'(bright_level - dark_level));
  endfunction

  // Update the shadow state and queue the result the transaction causes.
  function automatic void predict_stretch(in_item_t it);
    out_item_t r;
    logic err;
    err = bad_params();
    if (it.opcode == OP_ACCUMULATE) begin
      if (bin_count[it.pixel_in] != COUNT_MAX) bin_count[it.pixel_in]++;
      if (frame_count != COUNT_MAX) frame_count++;
      if (!it.frame_last) return;
      find_bounds();
      r.kind = KIND_REPORT;
      r.pixel_out = 8'd0;
      r.last_out = 1'b0;
    end else begin
      r.kind = KIND_PIXEL;
      r.pixel_out = err ? 8'd0 : stretch_level(it.pixel_in);
      r.last_out = it.frame_last;
    end
    r.low_bound = dark_level;
    r.high_bound = bright_level;
    r.status = err;
    expected_q.push_back(r);
    if (it.opcode == OP_MAP && it.frame_last) clear_histogram();
  endfunction

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        if (out_data !== expected_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, actual %p", expected_q[0], out_data);
        end
        void'(expected_q.pop_front());
      end
    end
  end

  // Receiver stalls.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One register write; the caller ends the last write of a sequence.
  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_BITS'({idx, 2'b00});
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_LOW_RATIO:  dark_ratio = value;
      REG_HIGH_RATIO: bright_ratio = value;
      REG_OUT_LOW:    floor_level = value[7:0];
      default:        ceil_level = value[7:0];
    endcase
  endtask

  // Valid stays high after an acceptance until the next idle cycle or drain.
  task automatic send_item(logic op, logic [7:0] pix, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{opcode: op, pixel_in: pix, frame_last: last};
    do @(posedge clk); while (!in_ready);
    predict_stretch('{opcode: op, pixel_in: pix, frame_last: last});
  endtask

  // Wait for all results, then let the bound search or divider settle.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic set_params(logic [15:0] lr, logic [15:0] hr, logic [7:0] ol,
                            logic [7:0] oh);
    drain();
    write_reg(REG_LOW_RATIO, lr);
    write_reg(REG_HIGH_RATIO, hr);
    write_reg(REG_OUT_LOW, {8'd0, ol});
    write_reg(REG_OUT_HIGH, {8'd0, oh});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One frame: accumulate pass, report, then map pass ending in a clear.
  task automatic run_frame(int n_acc, int n_map, int lo_px, int hi_px);
    for (int i = 0; i < n_acc; i++)
      send_item(OP_ACCUMULATE, 8'($urandom_range(hi_px, lo_px)), i == n_acc - 1);
    for (int i = 0; i < n_map; i++)
      send_item(OP_MAP, 8'($urandom_range(255)), i == n_map - 1);
  endtask

  typedef struct {
    logic       op;
    logic [7:0] pix;
    logic       last;
    logic       typed;
    out_item_t  want;
  } stim_row_t;

  stim_row_t directed[] = '{
    // A map right after reset: both bounds zero, pixel 0 sits on the bound.
    '{OP_MAP, 8'd0, 1'b0, 1'b1, '{KIND_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}},
    '{OP_MAP, 8'd255, 1'b1, 1'b1, '{KIND_PIXEL, 8'd255, 8'd0, 8'd0, 1'b0, 1'b1}},
    // Empty-ish pass with a single pixel at each extreme.
    '{OP_ACCUMULATE, 8'd0, 1'b0, 1'b0, '0},
    '{OP_ACCUMULATE, 8'd255, 1'b1, 1'b0, '0},
    '{OP_MAP, 8'd0, 1'b0, 1'b0, '0},
    '{OP_MAP, 8'd128, 1'b0, 1'b0, '0},
    '{OP_MAP, 8'd255, 1'b1, 1'b0, '0},
    // Single-level histogram gives equal bounds.
    '{OP_ACCUMULATE, 8'd77, 1'b0, 1'b0, '0},
    '{OP_ACCUMULATE, 8'd77, 1'b1, 1'b0, '0},
    '{OP_MAP, 8'd76, 1'b0, 1'b0, '0},
    '{OP_MAP, 8'd77, 1'b0, 1'b0, '0},
    '{OP_MAP, 8'd78, 1'b1, 1'b0, '0},
    '{OP_ACCUMULATE, 8'd10, 1'b0, 1'b0, '0},
    '{OP_ACCUMULATE, 8'd200, 1'b0, 1'b0, '0},
    '{OP_ACCUMULATE, 8'd170, 1'b1, 1'b0, '0},
    '{OP_MAP, 8'd85, 1'b0, 1'b0, '0},
    '{OP_MAP, 8'd170, 1'b1, 1'b0, '0}
  };

  initial begin
    int lr;
    int hr;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    dark_ratio = 16'd655;
    bright_ratio = 16'd655;
    floor_level = 8'd0;
    ceil_level = 8'd255;
    dark_level = '0;
    bright_level = '0;
    clear_histogram();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at reset settings.
    foreach (directed[i]) begin
      send_item(directed[i].op, directed[i].pix, directed[i].last);
      if (directed[i].typed) void'(expected_q.pop_back());
      if (directed[i].typed) expected_q.push_back(directed[i].want);
    end

    // Parameter errors: ratio sum at one, and inverted output range; then extreme ratios.
    set_params(16'd32768, 16'd32768, 8'd0, 8'd255);
    send_item(OP_ACCUMULATE, 8'd5, 1'b1);
    send_item(OP_MAP, 8'd9, 1'b1);
    set_params(16'd0, 16'd0, 8'd200, 8'd100);
    send_item(OP_MAP, 8'd3, 1'b1);
    set_params(16'd65535, 16'd0, 8'd255, 8'd255);
    run_frame(6, 4, 0, 255);
    set_params(16'd0, 16'd65535, 8'd0, 8'd0);
    run_frame(6, 4, 0, 255);

    // Random frames over several idling phases and settings.
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 19 : 77) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 19 : 77) : 0;
      lr = (ph == 7) ? 30000 : $urandom_range(20000);
      hr = (ph == 7) ? 40000 : $urandom_range(20000);
      set_params(16'(lr), 16'(hr), 8'($urandom_range(60)), 8'($urandom_range(255, 150)));
      for (int f = 0; f < 10; f++) begin
        if ($urandom_range(9) == 0) send_item(1'($urandom), 8'($urandom), 1'($urandom));
        else run_frame($urandom_range(1, 10), $urandom_range(1, 6),
                       $urandom_range(100), $urandom_range(255, 100));
      end
    end

    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
